[design/assert_macros.svh]
// Assertion macros shared by the RTL of the frame serializer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_CLK(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) \
    else $error("%m: assertion failed");

`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error("%m: forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rstn, prop)

`define ASSERT_NEVER(lbl, clk, rstn, cond)

`endif

`endif

[design/mlcd_pkg.sv]
// ----------------------------------------------------------------------------
// mlcd_pkg
// Sizes, command codes, shared types and helpers of the memory-LCD frame
// serializer.
// ----------------------------------------------------------------------------
package mlcd_pkg;

  localparam int ROW_BYTES   = 16;
  localparam int ROWS        = 128;
  localparam int STORE_DEPTH = ROWS * ROW_BYTES;

  localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W  = (ROW_BYTES > 1) ? $clog2(ROW_BYTES) : 1;

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(ROW_BYTES - 1);

  typedef enum logic [1:0] {
    FUNC_WRITE   = 2'd0,
    FUNC_REFRESH = 2'd1,
    FUNC_CLEAR   = 2'd2,
    FUNC_TOGGLE  = 2'd3
  } func_e;

  localparam logic [7:0] CMD_WRITE  = 8'b1000_0000;
  localparam logic [7:0] CMD_CLEAR  = 8'b0010_0000;
  localparam logic [7:0] CMD_TOGGLE = 8'b0000_0000;
  localparam logic [7:0] VCOM_BIT   = 8'b0100_0000;
  localparam logic [7:0] BYTE_ZERO  = 8'b0000_0000;
  localparam logic [7:0] BYTE_WHITE = 8'b1111_1111;

  // one beat leaving the sequencer; from_mem selects the RAM read data
  typedef struct packed {
    logic [7:0] spi_byte;
    logic       from_mem;
    logic       frame_end;
    logic       last;
  } beat_t;

  typedef struct packed {
    logic [7:0] spi_byte;
    logic       frame_end;
    logic       last;
  } out_beat_t;

  typedef struct packed {
    logic [1:0] count;
    logic       pop;
  } fifo_stat_t;

  typedef struct packed {
    logic              we;
    logic              re;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wdata;
  } ram_req_t;

  function automatic logic [7:0] reverse8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7-i];
    end
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] store_addr(input logic [ROW_W-1:0] row,
                                                   input logic [COL_W-1:0] col);
    return ADDR_W'(row * ROW_BYTES + col);
  endfunction

endpackage

[design/mlcd_in_if.sv]
// ----------------------------------------------------------------------------
// mlcd_in_if
// Request channel of the frame serializer: valid/ready plus request fields.
// ----------------------------------------------------------------------------
interface mlcd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] line;
  logic [5:0] column;
  logic [7:0] data;
  logic       first_line;
  logic       last_line;

  modport source (
    output valid, func, line, column, data, first_line, last_line,
    input  ready
  );

  modport sink (
    input  valid, func, line, column, data, first_line, last_line,
    output ready
  );
endinterface

[design/mlcd_out_if.sv]
// ----------------------------------------------------------------------------
// mlcd_out_if
// Byte channel of the frame serializer: valid/ready plus one link byte.
// ----------------------------------------------------------------------------
interface mlcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] spi_byte;
  logic       frame_end;
  logic       last;

  modport source (
    output valid, spi_byte, frame_end, last,
    input  ready
  );

  modport sink (
    input  valid, spi_byte, frame_end, last,
    output ready
  );
endinterface

[design/mlcd_store_ram.sv]
// ----------------------------------------------------------------------------
// mlcd_store_ram
// Single-port frame store, one byte per entry, registered read data.
// ----------------------------------------------------------------------------
module mlcd_store_ram (
  input  logic               clk_i,
  input  mlcd_pkg::ram_req_t req_i,
  output logic [7:0]         rdata_o
);

  logic [7:0] mem_q [mlcd_pkg::STORE_DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.addr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/mlcd_out_fifo.sv]
// ----------------------------------------------------------------------------
// mlcd_out_fifo
// Two-entry output queue; decouples the link side from the sequencer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mlcd_out_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  mlcd_pkg::out_beat_t  push_beat_i,
  mlcd_out_if.source           rsp_o,
  output mlcd_pkg::fifo_stat_t stat_o
);

  mlcd_pkg::out_beat_t entry_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] count_q, count_d;
  logic       pop;

  assign rsp_o.valid     = (count_q != 2'd0);
  assign rsp_o.spi_byte  = entry_q[rd_q].spi_byte;
  assign rsp_o.frame_end = entry_q[rd_q].frame_end;
  assign rsp_o.last      = entry_q[rd_q].last;

  assign pop = rsp_o.valid && rsp_o.ready;

  always_comb begin
    wr_d    = push_i ? ~wr_q : wr_q;
    rd_d    = pop ? ~rd_q : rd_q;
    count_d = count_q + {1'b0, push_i} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= push_beat_i;
    end
  end

  assign stat_o.count = count_q;
  assign stat_o.pop   = pop;

  // the sequencer's credit check keeps the queue from ever being pushed when full
  `ASSERT_NEVER(a_push_full, clk_i, rst_ni, push_i && count_q == 2'd2)
  `ASSERT_NEVER(a_count_range, clk_i, rst_ni, count_q == 2'd3)
  `ASSERT_CLK(a_count_up, clk_i, rst_ni, push_i && !pop |=> count_q == $past(count_q) + 2'd1)

endmodule

[design/mlcd_ctrl.sv]
// ----------------------------------------------------------------------------
// mlcd_ctrl
// Request sequencer: row valid bits, VCOM phase, store read/modify/write and
// byte issue toward the output queue.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mlcd_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  mlcd_in_if.sink              req_i,
  input  mlcd_pkg::fifo_stat_t fifo_i,
  output mlcd_pkg::ram_req_t   ram_o,
  output logic                 beat_valid_o,
  output mlcd_pkg::beat_t      beat_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_EMIT
  } state_e;

  typedef enum logic [2:0] {
    P_CMD,
    P_ADDR,
    P_ROW,
    P_TRAIL,
    P_END
  } phase_e;

  state_e                         state_q, state_d;
  phase_e                         phase_q, phase_d;
  mlcd_pkg::func_e                func_q, func_d;
  logic [7:0]                     line_q, line_d;
  logic [mlcd_pkg::COL_W-1:0]     col_q, col_d;
  logic [7:0]                     data_q, data_d;
  logic                           last_line_q, last_line_d;
  logic                           row_ok_q, row_ok_d;
  logic [mlcd_pkg::COL_W-1:0]     j_q, j_d;
  logic                           vcom_q, vcom_d;
  logic [mlcd_pkg::ROWS-1:0]      row_valid_q, row_valid_d;
  logic                           s1_valid_q, s1_valid_d;
  mlcd_pkg::beat_t                beat_q, beat_d;

  logic                           line_ok;
  logic                           col_ok;
  logic [mlcd_pkg::ROW_W-1:0]     row_in;
  logic [mlcd_pkg::COL_W-1:0]     col_in;
  logic [mlcd_pkg::ROW_W-1:0]     row_cur;
  logic                           issue_ok;
  logic [7:0]                     cmd_base;

  assign req_i.ready = (state_q == ST_IDLE);

  assign line_ok = ({1'b0, req_i.line} < 9'(mlcd_pkg::ROWS));
  assign col_ok  = ({1'b0, req_i.column} < 7'(mlcd_pkg::ROW_BYTES));
  assign row_in  = req_i.line[mlcd_pkg::ROW_W-1:0];
  assign col_in  = req_i.column[mlcd_pkg::COL_W-1:0];
  assign row_cur = line_q[mlcd_pkg::ROW_W-1:0];

  // one beat in flight plus queue fill must leave room once the RAM data lands
  assign issue_ok = ({1'b0, fifo_i.count} + {2'b00, s1_valid_q})
                    <= ({2'b00, fifo_i.pop} + 3'd1);

  always_comb begin
    case (func_q)
      mlcd_pkg::FUNC_REFRESH: cmd_base = mlcd_pkg::CMD_WRITE;
      mlcd_pkg::FUNC_CLEAR:   cmd_base = mlcd_pkg::CMD_CLEAR;
      default:                cmd_base = mlcd_pkg::CMD_TOGGLE;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    func_d      = func_q;
    line_d      = line_q;
    col_d       = col_q;
    data_d      = data_q;
    last_line_d = last_line_q;
    row_ok_d    = row_ok_q;
    j_d         = j_q;
    vcom_d      = vcom_q;
    row_valid_d = row_valid_q;
    s1_valid_d  = 1'b0;
    beat_d      = beat_q;
    ram_o.we    = 1'b0;
    ram_o.re    = 1'b0;
    ram_o.addr  = mlcd_pkg::store_addr(row_cur, j_q);
    ram_o.wdata = mlcd_pkg::BYTE_WHITE;

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          func_d      = mlcd_pkg::func_e'(req_i.func);
          line_d      = req_i.line;
          col_d       = col_in;
          data_d      = req_i.data;
          last_line_d = req_i.last_line;
          j_d         = '0;
          case (mlcd_pkg::func_e'(req_i.func))
            mlcd_pkg::FUNC_WRITE: begin
              if (line_ok && col_ok) begin
                if (row_valid_q[row_in]) begin
                  ram_o.we    = 1'b1;
                  ram_o.addr  = mlcd_pkg::store_addr(row_in, col_in);
                  ram_o.wdata = req_i.data;
                end else begin
                  // row still reads as white: write the whole row first
                  state_d = ST_FILL;
                end
              end
            end
            mlcd_pkg::FUNC_REFRESH: begin
              row_ok_d = line_ok && row_valid_q[row_in];
              phase_d  = req_i.first_line ? P_CMD : P_ADDR;
              state_d  = ST_EMIT;
            end
            mlcd_pkg::FUNC_CLEAR: begin
              row_valid_d = '0;
              phase_d     = P_CMD;
              state_d     = ST_EMIT;
            end
            default: begin
              phase_d = P_CMD;
              state_d = ST_EMIT;
            end
          endcase
        end
      end

      ST_FILL: begin
        ram_o.we    = 1'b1;
        ram_o.wdata = (j_q == col_q) ? data_q : mlcd_pkg::BYTE_WHITE;
        if (j_q == mlcd_pkg::LAST_COL) begin
          row_valid_d[row_cur] = 1'b1;
          state_d              = ST_IDLE;
        end else begin
          j_d = j_q + 1'b1;
        end
      end

      ST_EMIT: begin
        if (issue_ok) begin
          s1_valid_d       = 1'b1;
          beat_d.spi_byte  = mlcd_pkg::BYTE_ZERO;
          beat_d.from_mem  = 1'b0;
          beat_d.frame_end = 1'b0;
          beat_d.last      = 1'b0;
          case (phase_q)
            P_CMD: begin
              beat_d.spi_byte = cmd_base | (vcom_q ? mlcd_pkg::VCOM_BIT : mlcd_pkg::BYTE_ZERO);
              vcom_d          = ~vcom_q;
              phase_d         = (func_q == mlcd_pkg::FUNC_REFRESH) ? P_ADDR : P_END;
            end
            P_ADDR: begin
              beat_d.spi_byte = mlcd_pkg::reverse8(line_q);
              phase_d         = P_ROW;
            end
            P_ROW: begin
              if (row_ok_q) begin
                ram_o.re        = 1'b1;
                beat_d.from_mem = 1'b1;
              end else begin
                beat_d.spi_byte = mlcd_pkg::BYTE_WHITE;
              end
              if (j_q == mlcd_pkg::LAST_COL) begin
                phase_d = P_TRAIL;
              end else begin
                j_d = j_q + 1'b1;
              end
            end
            P_TRAIL: begin
              if (last_line_q) begin
                phase_d = P_END;
              end else begin
                beat_d.last = 1'b1;
                state_d     = ST_IDLE;
              end
            end
            P_END: begin
              beat_d.frame_end = 1'b1;
              beat_d.last      = 1'b1;
              state_d          = ST_IDLE;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      phase_q     <= P_CMD;
      vcom_q      <= 1'b0;
      row_valid_q <= '0;
      s1_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      vcom_q      <= vcom_d;
      row_valid_q <= row_valid_d;
      s1_valid_q  <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    func_q      <= func_d;
    line_q      <= line_d;
    col_q       <= col_d;
    data_q      <= data_d;
    last_line_q <= last_line_d;
    row_ok_q    <= row_ok_d;
    j_q         <= j_d;
    beat_q      <= beat_d;
  end

  assign beat_valid_o = s1_valid_q;
  assign beat_o       = beat_q;

  `ASSERT_NEVER(a_no_write_in_emit, clk_i, rst_ni, ram_o.we && state_q == ST_EMIT)
  `ASSERT_CLK(a_mem_beat_read, clk_i, rst_ni, s1_valid_q && beat_q.from_mem |-> $past(ram_o.re))
  `ASSERT_CLK(a_vcom_on_cmd, clk_i, rst_ni, vcom_q != $past(vcom_q) |-> $past(state_q == ST_EMIT && phase_q == P_CMD && issue_ok))

endmodule

[design/memory_lcd_frame_serializer_top.sv]
// ----------------------------------------------------------------------------
// memory_lcd_frame_serializer_top
// Frame store and byte serializer for a memory-LCD link.
//
//   channel  dir  handshake        payload
//   req_i    in   valid / ready    func, line, column, data, first_line, last_line
//   rsp_o    out  valid / ready    spi_byte, frame_end, last
//
// A write to a row cleared (by a clear or by reset) since it was last written
// rewrites the whole row, new byte included, through the single RAM port.
// Refresh issues one byte per cycle unless the output queue lacks room.
// Clear and toggle send a command and an end byte; a clear only drops valid bits.
// Reset clears the row valid bits at once, no sweep of the store is needed.
// A stalled link holds the sequencer once the two-entry output queue fills.
// ----------------------------------------------------------------------------
module memory_lcd_frame_serializer_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  mlcd_in_if.sink    req_i,
  mlcd_out_if.source rsp_o
);

  mlcd_pkg::ram_req_t   ram_req;
  logic [7:0]           ram_rdata;
  logic                 beat_valid;
  mlcd_pkg::beat_t      beat;
  mlcd_pkg::fifo_stat_t fifo_stat;
  mlcd_pkg::out_beat_t  push_beat;

  mlcd_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_i        (req_i),
    .fifo_i       (fifo_stat),
    .ram_o        (ram_req),
    .beat_valid_o (beat_valid),
    .beat_o       (beat)
  );

  mlcd_store_ram u_ram (
    .clk_i   (clk_i),
    .req_i   (ram_req),
    .rdata_o (ram_rdata)
  );

  // row bytes come from the RAM in the cycle after the read
  always_comb begin
    push_beat.spi_byte  = beat.from_mem ? ram_rdata : beat.spi_byte;
    push_beat.frame_end = beat.frame_end;
    push_beat.last      = beat.last;
  end

  mlcd_out_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (beat_valid),
    .push_beat_i (push_beat),
    .rsp_o       (rsp_o),
    .stat_o      (fifo_stat)
  );

endmodule

[tb/sv/mlcd_link_checker.sv]
// ----------------------------------------------------------------------------
// mlcd_link_checker
// Watches the request and link-byte channels of the frame serializer. Keeps
// its own frame store and VCOM phase, predicts the bytes that each accepted
// request sends, and compares every accepted link byte with the oldest one
// still waiting. The mismatch count and the number of waiting bytes go out.
// ----------------------------------------------------------------------------
module mlcd_link_checker
  import mlcd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  mlcd_in_if   req_mon,
  mlcd_out_if  rsp_mon,
  output int   mismatch_cnt_o,
  output int   pending_o
);

  logic [7:0] pixel_store [STORE_DEPTH];
  logic       vcom_q;
  out_beat_t  link_bytes_q [$];
  out_beat_t  item_beats   [$];
  out_beat_t  got_beat;
  out_beat_t  exp_beat;
  int         mismatch_cnt;

  task automatic add_beat(input logic [7:0] b, input logic fe);
    out_beat_t beat;
    beat.spi_byte  = b;
    beat.frame_end = fe;
    beat.last      = 1'b0;
    item_beats.push_back(beat);
  endtask

  // command byte carries the current VCOM phase, then the phase flips
  task automatic add_command(input logic [7:0] base);
    add_beat(base | (vcom_q ? VCOM_BIT : BYTE_ZERO), 1'b0);
    vcom_q = ~vcom_q;
  endtask

  task automatic predict_link_bytes(input func_e fn, input logic [7:0] row,
                                    input logic [5:0] col, input logic [7:0] pix,
                                    input logic opening, input logic closing);
    out_beat_t beat;
    item_beats.delete();
    case (fn)
      FUNC_WRITE: begin
        if (row < ROWS && col < ROW_BYTES) begin
          pixel_store[ADDR_W'(int'(row) * ROW_BYTES + int'(col))] = pix;
        end
      end
      FUNC_REFRESH: begin
        if (opening) add_command(CMD_WRITE);
        add_beat(reverse8(row), 1'b0);
        for (int j = 0; j < ROW_BYTES; j++) begin
          if (row < ROWS) add_beat(pixel_store[ADDR_W'(int'(row) * ROW_BYTES + j)], 1'b0);
          else            add_beat(BYTE_WHITE, 1'b0);
        end
        add_beat(BYTE_ZERO, 1'b0);
        if (closing) add_beat(BYTE_ZERO, 1'b1);
      end
      FUNC_CLEAR: begin
        for (int k = 0; k < STORE_DEPTH; k++) pixel_store[ADDR_W'(k)] = BYTE_WHITE;
        add_command(CMD_CLEAR);
        add_beat(BYTE_ZERO, 1'b1);
      end
      default: begin
        add_command(CMD_TOGGLE);
        add_beat(BYTE_ZERO, 1'b1);
      end
    endcase
    for (int i = 0; i < item_beats.size(); i++) begin
      beat      = item_beats[i];
      beat.last = (i == item_beats.size() - 1);
      link_bytes_q.push_back(beat);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < STORE_DEPTH; k++) pixel_store[ADDR_W'(k)] = BYTE_WHITE;
      vcom_q = 1'b0;
      link_bytes_q.delete();
      mismatch_cnt = 0;
      mismatch_cnt_o <= 0;
      pending_o      <= 0;
    end else begin
      // a byte can't belong to a request taken at the same edge
      if (rsp_mon.valid && rsp_mon.ready) begin
        got_beat.spi_byte  = rsp_mon.spi_byte;
        got_beat.frame_end = rsp_mon.frame_end;
        got_beat.last      = rsp_mon.last;
        if (link_bytes_q.size() == 0) begin
          $display("%0t: unexpected link byte: byte=%02h frame_end=%0b last=%0b",
                   $time, got_beat.spi_byte, got_beat.frame_end, got_beat.last);
          mismatch_cnt++;
        end else begin
          exp_beat = link_bytes_q.pop_front();
          if (got_beat.spi_byte !== exp_beat.spi_byte ||
              got_beat.frame_end !== exp_beat.frame_end ||
              got_beat.last !== exp_beat.last) begin
            $display("%0t: link byte mismatch: expected byte=%02h frame_end=%0b last=%0b, %s",
                     $time, exp_beat.spi_byte, exp_beat.frame_end, exp_beat.last,
                     $sformatf("got byte=%02h frame_end=%0b last=%0b",
                               got_beat.spi_byte, got_beat.frame_end, got_beat.last));
            mismatch_cnt++;
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        predict_link_bytes(func_e'(req_mon.func), req_mon.line, req_mon.column,
                           req_mon.data, req_mon.first_line, req_mon.last_line);
      end
      mismatch_cnt_o <= mismatch_cnt;
      pending_o      <= link_bytes_q.size();
    end
  end

endmodule

[tb/sv/tb_memory_lcd_frame_serializer_top.sv]
// ----------------------------------------------------------------------------
// tb_memory_lcd_frame_serializer_top
// Drives requests into the frame serializer and takes its link bytes with
// random gaps on both sides, a long link stall and a full drain. A directed
// part hits the field extremes and corner cases, then random row-write and
// refresh runs follow, mixed with clears, toggles and noise.
// ----------------------------------------------------------------------------
module tb_memory_lcd_frame_serializer_top;
  import mlcd_pkg::*;

  localparam int RAND_ITEMS = 85;
  localparam int LONG_HOLD  = 250;
  localparam int HOLD_AFTER = 300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   mismatch_cnt;
  int   pending;
  int   items_sent = 0;
  bit   snd_burst = 1'b0;

  mlcd_in_if  req_if ();
  mlcd_out_if rsp_if ();

  memory_lcd_frame_serializer_top u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  mlcd_link_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_mon        (req_if),
    .rsp_mon        (rsp_if),
    .mismatch_cnt_o (mismatch_cnt),
    .pending_o      (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(input bit burst);
    int r;
    if (burst) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_row();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(ROWS, 255));
    return 8'($urandom_range(0, ROWS - 1));
  endfunction

  function automatic logic [5:0] rand_col();
    if ($urandom_range(0, 9) == 0) return 6'($urandom_range(0, 63));
    return 6'($urandom_range(0, ROW_BYTES - 1));
  endfunction

  task automatic send_req(input func_e fn, input logic [7:0] ln, input logic [5:0] col,
                          input logic [7:0] pix, input logic opening, input logic closing);
    int gap;
    gap = pick_gap(snd_burst);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid      <= 1'b1;
    req_if.func       <= fn;
    req_if.line       <= ln;
    req_if.column     <= col;
    req_if.data       <= pix;
    req_if.first_line <= opening;
    req_if.last_line  <= closing;
    do @(posedge clk_i); while (!req_if.ready);
    items_sent++;
  endtask

  // called at the edge of the last transaction; pending is a registered copy
  task automatic drain_results();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // link side: random ready gaps, one long stall once traffic is flowing
  initial begin : link_sink
    int  gap;
    int  seen;
    bit  held;
    bit  burst;
    seen  = 0;
    held  = 1'b0;
    burst = 1'b0;
    rsp_if.ready <= 1'b0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      if (!held && seen >= HOLD_AFTER) begin
        held = 1'b1;
        rsp_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end
      gap = pick_gap(burst);
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      seen++;
      if (seen % 50 == 0) burst = ($urandom_range(0, 3) == 0);
    end
  end

  initial begin : stim
    logic [7:0] run_rows [$];
    int         rand_base;
    int         nw;
    int         nl;
    int         pick;
    bit         drained_mid;
    logic [7:0] row;

    req_if.valid      <= 1'b0;
    req_if.func       <= FUNC_WRITE;
    req_if.line       <= '0;
    req_if.column     <= '0;
    req_if.data       <= '0;
    req_if.first_line <= 1'b0;
    req_if.last_line  <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part
    send_req(FUNC_TOGGLE,  8'hFF, 6'h3F, 8'hFF, 1'b1, 1'b1);
    send_req(FUNC_TOGGLE,  8'h00, 6'h00, 8'h00, 1'b0, 1'b0);
    send_req(FUNC_REFRESH, 8'd0,   6'd0,  8'h00, 1'b1, 1'b1);
    send_req(FUNC_WRITE,   8'd0,   6'd0,  8'h00, 1'b0, 1'b0);
    send_req(FUNC_WRITE,   8'd0,   6'd15, 8'hA5, 1'b0, 1'b0);
    send_req(FUNC_WRITE,   8'd127, 6'd15, 8'h3C, 1'b0, 1'b0);
    send_req(FUNC_WRITE,   8'd127, 6'd0,  8'hC3, 1'b0, 1'b0);
    send_req(FUNC_WRITE,   8'd128, 6'd0,  8'h00, 1'b0, 1'b0);  // row out of range
    send_req(FUNC_WRITE,   8'd0,   6'd16, 8'h00, 1'b0, 1'b0);  // column out of range
    send_req(FUNC_WRITE,   8'd255, 6'd63, 8'h00, 1'b1, 1'b1);
    send_req(FUNC_REFRESH, 8'd0,   6'd0,  8'h00, 1'b1, 1'b0);
    send_req(FUNC_REFRESH, 8'd127, 6'd0,  8'h00, 1'b0, 1'b0);
    send_req(FUNC_REFRESH, 8'd255, 6'd0,  8'h00, 1'b0, 1'b1);  // sends all white
    send_req(FUNC_REFRESH, 8'd128, 6'h3F, 8'hFF, 1'b1, 1'b1);
    send_req(FUNC_CLEAR,   8'h5A,  6'h2A, 8'h99, 1'b1, 1'b0);
    send_req(FUNC_REFRESH, 8'd0,   6'd0,  8'h00, 1'b1, 1'b1);
    send_req(FUNC_WRITE,   8'd5,   6'd3,  8'h81, 1'b0, 1'b0);  // row cleared before
    send_req(FUNC_WRITE,   8'd5,   6'd0,  8'h7E, 1'b0, 1'b0);
    send_req(FUNC_REFRESH, 8'd5,   6'd0,  8'h00, 1'b1, 1'b1);
    send_req(FUNC_REFRESH, 8'd127, 6'd0,  8'h00, 1'b0, 1'b1);
    send_req(FUNC_WRITE,   8'd64,  6'd8,  8'h55, 1'b0, 1'b0);
    send_req(FUNC_REFRESH, 8'd64,  6'd0,  8'h00, 1'b1, 1'b0);
    send_req(FUNC_REFRESH, 8'd64,  6'd0,  8'h00, 1'b0, 1'b1);
    drain_results();

    // random part: write rows, then refresh them as one run
    rand_base   = items_sent;
    drained_mid = 1'b0;
    while (items_sent - rand_base < RAND_ITEMS) begin
      snd_burst = ($urandom_range(0, 4) == 0);
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        run_rows.delete();
        nw = $urandom_range(1, 6);
        for (int i = 0; i < nw; i++) begin
          row = rand_row();
          run_rows.push_back(row);
          send_req(FUNC_WRITE, row, rand_col(), 8'($urandom), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
        end
        nl = $urandom_range(1, 4);
        for (int i = 0; i < nl; i++) begin
          if ($urandom_range(0, 3) == 0) row = rand_row();
          else row = run_rows[$urandom_range(0, run_rows.size() - 1)];
          send_req(FUNC_REFRESH, row, 6'($urandom), 8'($urandom), (i == 0),
                   (i == nl - 1));
        end
      end else if (pick == 6) begin
        send_req(FUNC_CLEAR, 8'($urandom), 6'($urandom), 8'($urandom),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (pick == 7) begin
        send_req(FUNC_TOGGLE, 8'($urandom), 6'($urandom), 8'($urandom),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else if (pick == 8) begin
        send_req(func_e'($urandom_range(0, 3)), 8'($urandom), 6'($urandom), 8'($urandom),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        // broken runs: refreshes with random run flags
        nl = $urandom_range(1, 3);
        for (int i = 0; i < nl; i++) begin
          send_req(FUNC_REFRESH, rand_row(), 6'($urandom), 8'($urandom),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
      end
      if (!drained_mid && items_sent - rand_base >= RAND_ITEMS / 2) begin
        drained_mid = 1'b1;
        drain_results();
      end
    end

    drain_results();
    repeat (2 * ROW_BYTES + 8) @(posedge clk_i);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("** memory_lcd_frame_serializer_top: PASSED **");
    end else begin
      $display("** memory_lcd_frame_serializer_top: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #4000000;
    $display("** memory_lcd_frame_serializer_top: FAILED **");
    $finish;
  end

endmodule

[memory_lcd_frame_serializer_top.f]
+incdir+design
design/mlcd_pkg.sv
design/mlcd_in_if.sv
design/mlcd_out_if.sv
design/mlcd_store_ram.sv
design/mlcd_out_fifo.sv
design/mlcd_ctrl.sv
design/memory_lcd_frame_serializer_top.sv
tb/sv/mlcd_link_checker.sv
tb/sv/tb_memory_lcd_frame_serializer_top.sv
